@@ rtl/mt64_pkg.sv @@
// Shared constants, types and state codes for the 64-bit Mersenne Twister generator.
`default_nettype none

package mt64_pkg;

	// state memory geometry
	localparam int STATE_WORDS  = 312;
	localparam int SHIFT_OFFSET = 156;
	localparam int ADDR_W       = $clog2(STATE_WORDS);
	localparam int IDX_W        = $clog2(STATE_WORDS + 1);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// seeding recurrence
	localparam logic [63:0] INIT_MULT  = 64'd6364136223846793005;
	localparam int          INIT_SHIFT = 62;
	localparam logic [63:0] SEED_RESET = 64'd5489;

	// twist
	localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;

	// tempering
	localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
	localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;
	localparam int          TEMPER_SH_A   = 29;
	localparam int          TEMPER_SH_B   = 17;
	localparam int          TEMPER_SH_C   = 37;
	localparam int          TEMPER_SH_D   = 43;

	// request kinds (code 3 is ignored)
	localparam logic [1:0] KIND_RAW    = 2'd0;
	localparam logic [1:0] KIND_RANGED = 2'd1;
	localparam logic [1:0] KIND_RESEED = 2'd2;

	// configuration map
	localparam int             PADDR_W       = 4;
	localparam logic [PADDR_W-1:0] REG_SEED_ADDR = 4'd0;

	typedef enum logic [2:0] {
		CORE_FILL_START,
		CORE_FILL_WAIT,
		CORE_IDLE,
		CORE_TW_PRE,
		CORE_TW_RD,
		CORE_TW_WR,
		CORE_DRAW_RD,
		CORE_DRAW_DATA
	} core_state_t;

	typedef struct packed {
		logic valid;
		logic reseed;
	} core_req_t;

	typedef struct packed {
		logic        ready;
		logic        word_valid;
		logic [63:0] word;
	} core_rsp_t;

endpackage

`default_nettype wire

@@ rtl/mt64_mul.sv @@
// Low 64 bits of a 64-bit operand times the seeding multiplier, one 32x32 product per cycle.
`default_nettype none

module mt64_mul
	import mt64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] operand,
	output logic             done,
	output logic [63:0]      product
);

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_HL = 2'd1;
	localparam logic [1:0] STEP_LH = 2'd2;

	logic        busy_q;
	logic        done_q;
	logic [1:0]  step_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [31:0] mx;
	logic [31:0] my;
	logic [63:0] pp;

	// aL*bL, then the two cross terms into the upper half
	always_comb begin
		mx = (step_q == STEP_HL) ? a_q[63:32] : a_q[31:0];
		my = (step_q == STEP_LH) ? INIT_MULT[63:32] : INIT_MULT[31:0];
		pp = mx * my;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_LL;
		end else begin
			done_q <= busy_q && (step_q == STEP_LH);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				if (step_q == STEP_LH) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= operand;
		end
		if (busy_q) begin
			case (step_q)
				STEP_LL: acc_q <= pp;
				default: acc_q[63:32] <= acc_q[63:32] + pp[31:0];
			endcase
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

@@ rtl/mt64_div.sv @@
// Restoring 64-bit remainder unit, one quotient bit per cycle.
`default_nettype none

module mt64_div
	import mt64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [63:0]      rem
);

	localparam int         DIV_STEPS = 64;
	localparam int         CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]      rem_q;
	logic [63:0]      dq_q;
	logic [63:0]      d_q;
	logic [64:0]      trial;
	logic [64:0]      diff;

	always_comb begin
		trial = {rem_q, dq_q[63]};
		diff  = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= (trial >= {1'b0, d_q}) ? diff[63:0] : trial[63:0];
			dq_q  <= {dq_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/mt64_core.sv @@
// State memory with the seeding, twist and draw sequencer.
`default_nettype none

module mt64_core
	import mt64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [63:0] seed,
	input  wire core_req_t   req,
	output core_rsp_t        rsp
);

	localparam logic [ADDR_W:0] WORDS_C   = (ADDR_W + 1)'(STATE_WORDS);
	localparam logic [ADDR_W:0] OFFSET_C  = (ADDR_W + 1)'(SHIFT_OFFSET);
	localparam addr_t           LAST_ADDR = addr_t'(STATE_WORDS - 1);
	localparam idx_t            IDX_END   = idx_t'(STATE_WORDS);

	function automatic logic [63:0] temper(input logic [63:0] w);
		logic [63:0] x;
		x = w;
		x = x ^ ((x >> TEMPER_SH_A) & TEMPER_MASK_A);
		x = x ^ ((x << TEMPER_SH_B) & TEMPER_MASK_B);
		x = x ^ ((x << TEMPER_SH_C) & TEMPER_MASK_C);
		x = x ^ (x >> TEMPER_SH_D);
		return x;
	endfunction

	core_state_t state_q, state_d;

	logic [63:0] mem [STATE_WORDS];
	logic [63:0] rd_a_q;
	logic [63:0] rd_b_q;

	addr_t       i_q;
	idx_t        idx_q;
	logic [63:0] cur_q;

	logic        wr_en;
	addr_t       wr_addr;
	logic [63:0] wr_data;
	logic        rd_a_en;
	addr_t       rd_a_addr;
	logic        rd_b_en;
	addr_t       rd_b_addr;

	logic        mul_start;
	logic [63:0] mul_operand;
	logic        mul_done;
	logic [63:0] mul_product;

	logic [ADDR_W:0] nxt_sum;
	logic [ADDR_W:0] off_sum;
	addr_t           addr_nxt;
	addr_t           addr_off;
	logic [63:0]     fill_word;
	logic [63:0]     y;
	logic            last_i;

	mt64_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.operand (mul_operand),
		.done    (mul_done),
		.product (mul_product)
	);

	// wrapped neighbour and far-tap addresses for the twist
	always_comb begin
		nxt_sum   = {1'b0, i_q} + 1'b1;
		off_sum   = {1'b0, i_q} + OFFSET_C;
		addr_nxt  = (nxt_sum >= WORDS_C) ? addr_t'(nxt_sum - WORDS_C) : addr_t'(nxt_sum);
		addr_off  = (off_sum >= WORDS_C) ? addr_t'(off_sum - WORDS_C) : addr_t'(off_sum);
		fill_word = mul_product + 64'(i_q);
		y         = (cur_q & UPPER_MASK) | (rd_a_q & LOWER_MASK);
		last_i    = (i_q == LAST_ADDR);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CORE_FILL_START: state_d = CORE_FILL_WAIT;
			CORE_FILL_WAIT: begin
				if (mul_done && last_i) begin
					state_d = CORE_IDLE;
				end
			end
			CORE_IDLE: begin
				if (req.valid) begin
					if (req.reseed) begin
						state_d = CORE_FILL_START;
					end else if (idx_q >= IDX_END) begin
						state_d = CORE_TW_PRE;
					end else begin
						state_d = CORE_DRAW_RD;
					end
				end
			end
			CORE_TW_PRE:    state_d = CORE_TW_RD;
			CORE_TW_RD:     state_d = CORE_TW_WR;
			CORE_TW_WR:     state_d = last_i ? CORE_DRAW_RD : CORE_TW_RD;
			CORE_DRAW_RD:   state_d = CORE_DRAW_DATA;
			CORE_DRAW_DATA: state_d = CORE_IDLE;
			default:        state_d = CORE_IDLE;
		endcase
	end

	always_comb begin
		wr_en          = 1'b0;
		wr_addr        = i_q;
		wr_data        = fill_word;
		rd_a_en        = 1'b0;
		rd_a_addr      = addr_nxt;
		rd_b_en        = 1'b0;
		rd_b_addr      = addr_off;
		mul_start      = 1'b0;
		mul_operand    = fill_word ^ (fill_word >> INIT_SHIFT);
		rsp.ready      = 1'b0;
		rsp.word_valid = 1'b0;
		rsp.word       = temper(rd_a_q);
		unique case (state_q)
			CORE_FILL_START: begin
				wr_en       = 1'b1;
				wr_addr     = '0;
				wr_data     = seed;
				mul_start   = 1'b1;
				mul_operand = seed ^ (seed >> INIT_SHIFT);
			end
			CORE_FILL_WAIT: begin
				wr_en     = mul_done;
				mul_start = mul_done && !last_i;
			end
			CORE_IDLE: rsp.ready = 1'b1;
			CORE_TW_PRE: begin
				rd_a_en   = 1'b1;
				rd_a_addr = '0;
			end
			CORE_TW_RD: begin
				rd_a_en = 1'b1;
				rd_b_en = 1'b1;
			end
			CORE_TW_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_b_q ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 64'd0);
			end
			CORE_DRAW_RD: begin
				rd_a_en   = 1'b1;
				rd_a_addr = idx_q[ADDR_W-1:0];
			end
			CORE_DRAW_DATA: rsp.word_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_FILL_START;
			i_q     <= '0;
			idx_q   <= IDX_END;
		end else begin
			state_q <= state_d;
			case (state_q)
				CORE_FILL_START: i_q <= addr_t'(1);
				CORE_FILL_WAIT: begin
					if (mul_done) begin
						i_q <= addr_nxt;
						if (last_i) begin
							idx_q <= IDX_END;
						end
					end
				end
				CORE_IDLE: i_q <= '0;
				CORE_TW_WR: begin
					i_q <= addr_nxt;
					if (last_i) begin
						idx_q <= '0;
					end
				end
				CORE_DRAW_DATA: idx_q <= idx_t'(idx_q + 1'b1);
				default: ;
			endcase
		end
	end

	// carry word i+1 forward as the next word i; at i = 0 word 0 comes from the priming read
	always_ff @(posedge clk) begin
		if (state_q == CORE_TW_WR || (state_q == CORE_TW_RD && i_q == '0)) begin
			cur_q <= rd_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_a_en) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= mem[rd_b_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_64_generator.sv @@
// Top level of the MT19937-64 generator: APB seed register, request stream, result queue.
// Raw draw: the word is read, then tempered and written to the result queue; no new request
// is taken until that result is queued. Ranged draw: a bit-serial remainder unit follows
// (operand load, then 64 one-bit steps). The first draw after a fill and every 312th after
// it first regenerate the state memory: a priming read, then per word a read of two words and
// the write of the new word. Reset (arst_n low, asynchronous) loads seed 5489, then fills the
// memory from it word by word through the shared 32x32 multiplier; a reseed repeats the fill.
`default_nettype none

module mersenne_twister_64_generator
	import mt64_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	// request stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [127:0]       s_tdata,  // [63:0] low_bound, [127:64] high_bound
	input  wire logic [1:0]         s_tuser,  // [1:0] kind
	// result stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [63:0]             m_tdata,  // [63:0] value
	output logic [0:0]              m_tuser   // [0] range_error
);

	localparam logic [1:0] FIFO_FULL = 2'd2;

	logic [63:0] seed_q;
	logic        cfg_wr;

	logic        in_acc;
	logic        is_draw;
	logic        is_reseed;
	logic        busy_q;
	logic        ranged_q;
	logic [63:0] lo_q;
	logic [63:0] span_q;

	core_req_t   core_req;
	core_rsp_t   core_rsp;

	logic        div_start;
	logic        div_done;
	logic [63:0] div_rem;

	logic        push;
	logic        pop;
	logic [63:0] push_val;
	logic        push_err;
	logic [63:0] fifo_val_q [2];
	logic        fifo_err_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	// ---- configuration port; the seed only takes effect on a reseed (reset restores 5489)
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_SEED_ADDR);
	assign prdata = (paddr == REG_SEED_ADDR) ? seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_wr) begin
			seed_q <= pwdata;
		end
	end

	// ---- request intake: one request at a time, with room kept for its result
	assign s_tready  = core_rsp.ready && !busy_q && (cnt_q != FIFO_FULL);
	assign in_acc    = s_tvalid && s_tready;
	assign is_draw   = (s_tuser == KIND_RAW) || (s_tuser == KIND_RANGED);
	assign is_reseed = (s_tuser == KIND_RESEED);

	assign core_req.valid  = in_acc && (is_draw || is_reseed);
	assign core_req.reseed = is_reseed;

	mt64_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.seed   (seed_q),
		.req    (core_req),
		.rsp    (core_rsp)
	);

	mt64_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (core_rsp.word),
		.divisor  (span_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// ---- result selection: raw word, low bound on an empty span, or low + remainder
	always_comb begin
		push      = 1'b0;
		push_val  = core_rsp.word;
		push_err  = 1'b0;
		div_start = 1'b0;
		if (core_rsp.word_valid) begin
			if (!ranged_q) begin
				push = 1'b1;
			end else if (span_q == 64'd0) begin
				push     = 1'b1;
				push_val = lo_q;
				push_err = 1'b1;
			end else begin
				div_start = 1'b1;
			end
		end
		if (div_done) begin
			push     = 1'b1;
			push_val = lo_q + div_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc && is_draw) begin
			busy_q <= 1'b1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	// span wraps modulo 2^64 when the bounds are reversed
	always_ff @(posedge clk) begin
		if (in_acc && is_draw) begin
			ranged_q <= (s_tuser == KIND_RANGED);
			lo_q     <= s_tdata[63:0];
			span_q   <= s_tdata[127:64] - s_tdata[63:0];
		end
	end

	// ---- two-entry result queue, decouples the master side from the core
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = fifo_val_q[rd_ptr_q];
	assign m_tuser  = fifo_err_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_val_q[wr_ptr_q] <= push_val;
			fifo_err_q[wr_ptr_q] <= push_err;
		end
	end

endmodule

`default_nettype wire

@@ rtl/mt64_checker.sv @@
// Port-level assertions for the generator, bound to the top level.
`default_nettype none

module mt64_checker
	import mt64_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pready,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic [1:0]         s_tuser,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [63:0]        m_tdata,
	input wire logic [0:0]         m_tuser
);

	// no request is taken while reset holds the memory fill
	a_reset_no_ready: assert property (@(posedge clk) !arst_n |-> !s_tready)
		else $error("s_tready high during reset");

	// a draw or reseed occupies the block for at least the following cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready &&
		 (s_tuser == KIND_RAW || s_tuser == KIND_RANGED || s_tuser == KIND_RESEED))
		|=> !s_tready)
		else $error("request taken while previous one still in progress");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// configuration writes complete without wait states
	a_apb_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable) |-> pready)
		else $error("APB access stalled");

endmodule

bind mersenne_twister_64_generator mt64_checker u_mt64_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pready   (pready),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/tb_mersenne_twister_64_generator.sv @@
// Self-checking testbench for the MT19937-64 generator: streamed draws against an in-bench model.
`timescale 1ns / 1ps

module tb_mersenne_twister_64_generator;
	import mt64_pkg::PADDR_W;
	import mt64_pkg::REG_SEED_ADDR;
	import mt64_pkg::KIND_RAW;
	import mt64_pkg::KIND_RANGED;
	import mt64_pkg::KIND_RESEED;

	// kind code 3 carries no meaning: the block drops it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// register index 1 would sit here; nothing is mapped there
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 4'd8;

	// generator geometry and constants, kept apart from the package on purpose
	localparam int          MT_WORDS   = 312;
	localparam int          MT_MIDDLE  = 156;
	localparam logic [63:0] MT_MULT    = 64'd6364136223846793005;
	localparam logic [63:0] MT_MATRIX  = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] MT_UPPER   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] MT_LOWER   = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MT_TEMPER_A = 64'h5555_5555_5555_5555;
	localparam logic [63:0] MT_TEMPER_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] MT_TEMPER_C = 64'hFFF7_EEE0_0000_0000;
	localparam logic [63:0] SEED_AT_RESET = 64'd5489;
	localparam logic [63:0] ALL_ONES = '1;

	// a reseed request leaves no result behind, so allow for the fill that it starts
	localparam int SETTLE_CYCLES = 1400;
	localparam int TAIL_CYCLES   = 2000;
	localparam int HOLD_CYCLES   = 600;
	localparam int REPORT_LIMIT  = 40;
	localparam int RANDOM_ROUNDS = 5;
	localparam int ROUND_ITEMS   = 310;

	typedef struct packed {
		logic [63:0] value;
		logic        range_error;
	} result_t;

	typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
	typedef enum int unsigned {
		BOUNDS_FREE, BOUNDS_EQUAL, BOUNDS_NARROW, BOUNDS_POW2, BOUNDS_ORDERED, BOUNDS_REVERSED
	} bound_shape_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [63:0]        pwdata;
	logic [63:0]        prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	logic [127:0]       s_tdata;   // [63:0] low_bound, [127:64] high_bound
	logic [1:0]         s_tuser;   // [1:0] kind
	logic               m_tvalid;
	logic               m_tready;
	logic [63:0]        m_tdata;   // [63:0] value
	logic [0:0]         m_tuser;   // [0] range_error

	mersenne_twister_64_generator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------------
	// Predictor: own copy of the twister state and of the seed register
	// ---------------------------------------------------------------------------
	logic [63:0] twister_state [MT_WORDS];
	int unsigned twister_pos;
	logic [63:0] seed_value;
	result_t     pending_results [$];

	int unsigned fail_count;
	int unsigned n_checked, n_raw, n_ranged, n_equal, n_reseed, n_ignored, n_seed_writes;

	// standard initialisation recurrence; leaves the index past the end
	function automatic void load_twister(input logic [63:0] s);
		twister_state[0] = s;
		for (int i = 1; i < MT_WORDS; i++)
			twister_state[i] = MT_MULT * (twister_state[i-1] ^ (twister_state[i-1] >> 62))
				+ 64'(i);
		twister_pos = MT_WORDS;
	endfunction

	function automatic void regenerate_twister();
		logic [63:0] y;
		for (int i = 0; i < MT_WORDS; i++) begin
			y = (twister_state[i] & MT_UPPER) | (twister_state[(i + 1) % MT_WORDS] & MT_LOWER);
			twister_state[i] = twister_state[(i + MT_MIDDLE) % MT_WORDS] ^ (y >> 1)
				^ (y[0] ? MT_MATRIX : 64'd0);
		end
		twister_pos = 0;
	endfunction

	function automatic logic [63:0] next_tempered();
		logic [63:0] x;
		if (twister_pos >= MT_WORDS)
			regenerate_twister();
		x = twister_state[twister_pos];
		twister_pos++;
		x ^= (x >> 29) & MT_TEMPER_A;
		x ^= (x << 17) & MT_TEMPER_B;
		x ^= (x << 37) & MT_TEMPER_C;
		x ^= (x >> 43);
		return x;
	endfunction

	// runs once per accepted request and queues what the block must return
	function automatic void predict_request(input logic [1:0] kind, input logic [63:0] lo,
			input logic [63:0] hi);
		logic [63:0] word;
		logic [63:0] span;
		case (kind)
			KIND_RAW: begin
				pending_results.push_back('{value: next_tempered(), range_error: 1'b0});
				n_raw++;
			end
			KIND_RANGED: begin
				word = next_tempered();
				span = hi - lo;   // wraps when the bounds are reversed
				if (span == 64'd0) begin
					pending_results.push_back('{value: lo, range_error: 1'b1});
					n_equal++;
				end else begin
					pending_results.push_back('{value: lo + (word % span), range_error: 1'b0});
				end
				n_ranged++;
			end
			KIND_RESEED: begin
				load_twister(seed_value);
				n_reseed++;
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// ---------------------------------------------------------------------------
	// Result side: back-pressure pattern and checker
	// ---------------------------------------------------------------------------
	int unsigned rx_hold_cycles;   // set by a test, counted down here
	int unsigned rx_phase_left;
	int unsigned rx_tick;
	rx_mode_t    rx_mode;

	always @(posedge clk) begin
		rx_tick++;
		if (rx_hold_cycles > 0) begin
			m_tready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode       = rx_mode_t'($urandom_range(0, 3));
				rx_phase_left = $urandom_range(32, 256);
			end
			rx_phase_left--;
			case (rx_mode)
				RX_FREE:     m_tready <= 1'b1;
				RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: m_tready <= ((rx_tick % 5) != 0);
			endcase
		end
	end

	// values read here are the ones held before the edge, so no race with the drivers
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t ns: result with nothing expected, got value %h range_error %b",
						$time, m_tdata, m_tuser[0]);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (m_tdata !== want.value) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t ns: value expected %h, got %h",
							$time, want.value, m_tdata);
				end
				if (m_tuser[0] !== want.range_error) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t ns: range_error expected %b, got %b",
							$time, want.range_error, m_tuser[0]);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------------
	int unsigned burst_left;
	bit          sender_steady;   // no gaps while set

	// offers one request, waits for the handshake, then predicts it;
	// tvalid stays high on return so back-to-back requests need no re-raise
	task automatic send_request(input logic [1:0] kind, input logic [63:0] lo,
			input logic [63:0] hi);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 :
				($urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {hi, lo};
		do @(posedge clk); while (!s_tready);
		predict_request(kind, lo, hi);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// idle point for register traffic: a trailing reseed may still be filling
	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == REG_SEED_ADDR)
			seed_value = data;
		n_seed_writes++;
	endtask

	task automatic apb_read_seed();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= REG_SEED_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (prdata !== seed_value) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t ns: seed read expected %h, got %h", $time, seed_value, prdata);
		end
	endtask

	task automatic send_random_request();
		int unsigned  pick;
		bound_shape_t shape;
		logic [63:0]  lo, hi, tmp;
		logic [1:0]   kind;
		pick = $urandom_range(0, 99);
		lo   = rand64();
		hi   = rand64();
		if (pick < 55)      kind = KIND_RAW;
		else if (pick < 91) kind = KIND_RANGED;
		else if (pick < 95) kind = KIND_RESEED;
		else                kind = KIND_UNUSED;
		if (kind == KIND_RANGED) begin
			shape = bound_shape_t'($urandom_range(0, 5));
			case (shape)
				BOUNDS_FREE:     ;
				BOUNDS_EQUAL:    hi = lo;
				BOUNDS_NARROW:   hi = lo + 64'($urandom_range(1, 16));
				BOUNDS_POW2:     hi = lo + (64'd1 << $urandom_range(0, 63));
				BOUNDS_ORDERED: begin
					if (hi < lo) begin
						tmp = lo;
						lo  = hi;
						hi  = tmp;
					end
				end
				BOUNDS_REVERSED: hi = lo - 64'($urandom_range(1, 16));
			endcase
		end
		send_request(kind, lo, hi);
	endtask

	// ---------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------

	// state straight out of reset comes from the reset seed; the block is still
	// filling, so the first requests simply wait on tready
	task automatic test_reset_seed();
		repeat (4) send_request(KIND_RAW, rand64(), rand64());
	endtask

	// bound extremes, every kind and each named corner case
	task automatic test_directed_cases();
		logic [63:0] r;
		r = rand64();
		send_request(KIND_RANGED, 64'd0, ALL_ONES);
		send_request(KIND_RANGED, ALL_ONES, 64'd0);          // reversed: span wraps to 1
		send_request(KIND_RANGED, 64'd0, 64'd1);
		send_request(KIND_RANGED, 64'd0, 64'd0);             // equal bounds
		send_request(KIND_RANGED, ALL_ONES, ALL_ONES);
		send_request(KIND_RANGED, r, r);
		send_request(KIND_RANGED, ALL_ONES, ALL_ONES - 64'd1); // reversed, near-full span
		send_request(KIND_RANGED, 64'h8000_0000_0000_0000, rand64());
		send_request(KIND_RAW, ALL_ONES, ALL_ONES);          // bounds ignored on a raw draw
		send_request(KIND_RAW, rand64(), rand64());
		send_request(KIND_UNUSED, rand64(), rand64());       // dropped, no result
		send_request(KIND_UNUSED, ALL_ONES, ALL_ONES);
		send_request(KIND_RAW, 64'd0, 64'd0);
		send_request(KIND_RESEED, 64'd0, 64'd0);             // back to the reset seed
		send_request(KIND_RAW, 64'd0, 64'd0);
	endtask

	// seed register: write alone leaves the state, reseed picks it up,
	// unmapped address ignored; extremes and a random value
	task automatic test_seed_register();
		logic [63:0] seeds [4];
		seeds = '{64'd0, ALL_ONES, 64'd1, rand64()};
		foreach (seeds[k]) begin
			settle_block();
			apb_write(REG_SEED_ADDR, seeds[k]);
			apb_read_seed();
			apb_write(UNMAPPED_ADDR, rand64());
			apb_read_seed();
			repeat (2) send_request(KIND_RAW, rand64(), rand64());   // old state carries on
			send_request(KIND_RESEED, rand64(), rand64());
			send_request(KIND_RAW, rand64(), rand64());
			send_request(KIND_RANGED, rand64(), rand64());
		end
	endtask

	// fresh state then more than a full table of draws: two regenerations
	task automatic test_twist_boundary();
		sender_steady = 1'b1;
		send_request(KIND_RESEED, 64'd0, 64'd0);
		repeat (MT_WORDS + 8) send_request(KIND_RAW, rand64(), rand64());
		sender_steady = 1'b0;
	endtask

	// long receiver hold-off while requests keep coming, then a full drain
	task automatic test_backpressure();
		rx_hold_cycles = HOLD_CYCLES;
		sender_steady  = 1'b1;
		repeat (48) send_request($urandom_range(0, 3) == 0 ? KIND_RANGED : KIND_RAW,
			rand64(), rand64());
		sender_steady = 1'b0;
		drain_results();
	endtask

	// random traffic in rounds; each writes a fresh seed and picks it up by a reseed only at random
	task automatic test_random_traffic();
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			settle_block();
			apb_write(REG_SEED_ADDR, $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				send_request(KIND_RESEED, rand64(), rand64());
			sender_steady = ($urandom_range(0, 2) == 0);
			repeat (ROUND_ITEMS) send_random_request();
		end
		sender_steady = 1'b0;
	endtask

	// ---------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_RAW;
		m_tready = 1'b0;
		seed_value = SEED_AT_RESET;
		load_twister(seed_value);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_directed_cases();
		test_seed_register();
		test_twist_boundary();
		test_backpressure();
		test_random_traffic();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d raw and %0d ranged draws (%0d with equal bounds).",
			n_checked, n_raw, n_ranged, n_equal);
		$display("Also %0d reseeds, %0d dropped requests, %0d register writes.",
			n_reseed, n_ignored, n_seed_writes);
		if (fail_count == 0)
			$display("mersenne_twister_64_generator: match");
		else
			$display("mersenne_twister_64_generator: mismatch");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("mersenne_twister_64_generator: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mt64_pkg.sv
rtl/mt64_mul.sv
rtl/mt64_div.sv
rtl/mt64_core.sv
rtl/mersenne_twister_64_generator.sv
rtl/mt64_checker.sv
dv/tb_mersenne_twister_64_generator.sv
